// File: design/glos_pkg.sv
// Shared types and constants of the grid line-of-sight caster.
`default_nettype none

package glos_pkg;

  localparam int COORD_W = 6;
  localparam int ERR_W   = COORD_W + 3;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COORD_W:0]   count_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_CAST  = 1'b1
  } cmd_e_t;

  typedef enum logic {
    REG_ORIGIN_X = 1'b0,
    REG_ORIGIN_Y = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_WALK,
    OP_TRACE
  } op_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_PRIME,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic   cmd;
    coord_t target_x;
    coord_t target_y;
    logic   opaque_in;
  } item_t;

  typedef struct packed {
    coord_t cell_x;
    coord_t cell_y;
    logic   last_cell;
  } cell_t;

  // One classified operation. For a write, a and b are the column and row.
  typedef struct packed {
    op_kind_t kind;
    coord_t   a;
    coord_t   b;
    logic     steep;
    logic     dec_a;
    logic     dec_b;
    coord_t   da;
    coord_t   db;
    count_t   count;
    logic     opaque;
  } op_t;

endpackage

`default_nettype wire

// File: design/glos_if.sv
// Valid/ready channel interfaces for the item input and the cell output.
`default_nettype none

interface glos_item_if;
  logic            valid;
  logic            ready;
  glos_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface glos_cell_if;
  logic            valid;
  logic            ready;
  glos_pkg::cell_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/glos_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module glos_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [AW-1:0]            raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

`default_nettype wire

// File: design/glos_front.sv
// Front end: accepts items and turns each into a classified operation.
`default_nettype none

module glos_front #(
  parameter int GRID_SIZE = 64
) (
  glos_item_if.sink             items,
  input  wire glos_pkg::coord_t origin_x,
  input  wire glos_pkg::coord_t origin_y,
  input  wire logic             clearing,
  input  wire logic             q_ready,
  output logic                  q_valid,
  output glos_pkg::op_t         op
);
  import glos_pkg::*;

  coord_t tx, ty, dxa, dya, oa, ob, ta, tb, da, db;
  logic   is_cast, in_grid, straight, steep, rev;

  assign tx = items.data.target_x;
  assign ty = items.data.target_y;
  assign is_cast = (items.data.cmd == CMD_CAST);

  always_comb begin
    dxa = (tx > origin_x) ? tx - origin_x : origin_x - tx;
    dya = (ty > origin_y) ? ty - origin_y : origin_y - ty;
    straight = (tx == origin_x) || (ty == origin_y);
    // A straight ray runs along y when the columns agree.
    steep = straight ? (tx == origin_x) : (dya > dxa);
    oa = steep ? origin_y : origin_x;
    ob = steep ? origin_x : origin_y;
    ta = steep ? ty : tx;
    tb = steep ? tx : ty;
    da = steep ? dya : dxa;
    db = steep ? dxa : dya;
    rev = oa > ta;

    in_grid = (int'(tx) < GRID_SIZE) && (int'(ty) < GRID_SIZE);
    if (is_cast) begin
      in_grid = in_grid && (int'(origin_x) < GRID_SIZE) && (int'(origin_y) < GRID_SIZE);
    end

    op = '0;
    op.da = da;
    op.steep = steep;
    if (!is_cast) begin
      op.kind = OP_WRITE;
      op.a = tx;
      op.b = ty;
      op.steep = 1'b0;
      op.opaque = items.data.opaque_in;
    end else if (straight) begin
      op.kind = OP_WALK;
      op.a = oa;
      op.b = ob;
      op.dec_a = ta < oa;
      op.count = {1'b0, da} + count_t'(1);
    end else if (!rev) begin
      op.kind = OP_WALK;
      op.a = oa;
      op.b = ob;
      op.db = db;
      op.dec_b = tb < ob;
      op.count = {1'b0, da};
    end else begin
      // Traced from the target toward the origin, then played back.
      op.kind = OP_TRACE;
      op.a = ta;
      op.b = tb;
      op.db = db;
      op.dec_b = ob < tb;
      op.count = {1'b0, da};
    end
  end

  assign items.ready = !clearing && q_ready;
  assign q_valid = items.valid && items.ready && in_grid;
endmodule

`default_nettype wire

// File: design/glos_queue.sv
// Two-entry operation queue between the front end and the ray engine.
`default_nettype none

module glos_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  input  wire glos_pkg::op_t push_op,
  output logic               push_ready,
  output logic               pop_valid,
  output glos_pkg::op_t      pop_op,
  input  wire logic          pop_ready
);
  import glos_pkg::*;

  op_t        slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_op = slots[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("operation queue count overflowed");
endmodule

`default_nettype wire

// File: design/glos_back.sv
// Ray engine: owns the opacity grid, steps rays and drives the cell output.
`default_nettype none

module glos_back #(
  parameter int GRID_SIZE = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          op_valid,
  input  wire glos_pkg::op_t op,
  output logic               op_ready,
  glos_cell_if.source        cells,
  output logic               clearing
);
  import glos_pkg::*;

  localparam int CELLS  = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int IDX_W  = $clog2(GRID_SIZE);

  function automatic logic [ADDR_W-1:0] cell_addr(coord_t x, coord_t y);
    logic [ADDR_W-1:0] row;
    row = ADDR_W'(ADDR_W'(y) * ADDR_W'(GRID_SIZE));
    return row + ADDR_W'(x);
  endfunction

  state_t state, state_next;
  logic [ADDR_W-1:0] clr_addr;

  // Bresenham stepper.
  coord_t a, b, da, db;
  logic   steep, dec_a, dec_b;
  logic signed [ERR_W-1:0] err, err_sub, err_next;
  logic   minor_step, step_en;
  coord_t sx, sy;

  count_t rem, span;
  logic [IDX_W-1:0] widx;
  logic   from_store, gen_valid;
  coord_t gx, gy;

  // Opacity lookup stage and output register.
  logic   pb, b_cnt_last, b_last;
  coord_t bx, by;
  logic   ov;
  cell_t  obeat;
  logic   out_free, b_move, fin, issue, take;

  logic              grid_we, grid_re, grid_wdata, grid_rdata;
  logic [ADDR_W-1:0] grid_waddr;
  logic              store_we, store_re;
  logic [IDX_W-1:0]  store_raddr;
  logic [2*COORD_W-1:0] store_rdata;

  assign err_sub = err - $signed({2'b00, db, 1'b0});
  assign minor_step = err_sub[ERR_W-1];
  assign err_next = minor_step ? err_sub + $signed({2'b00, da, 1'b0}) : err_sub;
  assign sx = steep ? b : a;
  assign sy = steep ? a : b;
  assign gx = from_store ? store_rdata[COORD_W-1:0] : sx;
  assign gy = from_store ? store_rdata[2*COORD_W-1:COORD_W] : sy;

  assign out_free = !ov || cells.ready;
  assign b_last = b_cnt_last || grid_rdata;
  assign b_move = pb && out_free;
  assign fin = b_move && b_last;
  assign issue = (state == ST_RUN) && gen_valid && (!pb || b_move) && !fin;
  assign take = op_valid && op_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (op_valid) begin
          case (op.kind)
            OP_WALK:  state_next = ST_RUN;
            OP_TRACE: state_next = ST_FILL;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        if (rem == count_t'(1)) begin
          state_next = ST_PRIME;
        end
      end
      ST_PRIME: state_next = ST_RUN;
      ST_RUN: begin
        if (fin) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    op_ready = 1'b0;
    clearing = 1'b0;
    grid_we = 1'b0;
    grid_waddr = clr_addr;
    grid_wdata = 1'b0;
    store_we = 1'b0;
    store_re = 1'b0;
    store_raddr = IDX_W'(rem - count_t'(2));
    step_en = 1'b0;
    case (state)
      ST_CLEAR: begin
        clearing = 1'b1;
        grid_we = 1'b1;
      end
      ST_IDLE: begin
        op_ready = 1'b1;
        if (op_valid && (op.kind == OP_WRITE)) begin
          grid_we = 1'b1;
          grid_waddr = cell_addr(op.a, op.b);
          grid_wdata = op.opaque;
        end
      end
      ST_FILL: begin
        store_we = 1'b1;
        step_en = 1'b1;
      end
      ST_PRIME: begin
        store_re = 1'b1;
        store_raddr = IDX_W'(span - count_t'(1));
      end
      ST_RUN: begin
        store_re = issue && from_store && (rem != count_t'(1));
        step_en = issue && !from_store;
      end
      default: begin
      end
    endcase
  end

  assign grid_re = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      gen_valid <= 1'b0;
      pb <= 1'b0;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (take && (op.kind == OP_WALK)) begin
        gen_valid <= 1'b1;
      end else if (state == ST_PRIME) begin
        gen_valid <= 1'b1;
      end else if (fin || (issue && (rem == count_t'(1)))) begin
        gen_valid <= 1'b0;
      end
      if (issue) begin
        pb <= 1'b1;
      end else if (b_move) begin
        pb <= 1'b0;
      end
      if (b_move) begin
        ov <= 1'b1;
      end else if (cells.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && (op.kind != OP_WRITE)) begin
      a <= op.a;
      b <= op.b;
      steep <= op.steep;
      dec_a <= op.dec_a;
      dec_b <= op.dec_b;
      da <= op.da;
      db <= op.db;
      err <= $signed({3'b000, op.da});
      rem <= op.count;
      span <= op.count;
      widx <= '0;
      from_store <= (op.kind == OP_TRACE);
    end else begin
      if (step_en) begin
        a <= dec_a ? a - coord_t'(1) : a + coord_t'(1);
        if (minor_step) begin
          b <= dec_b ? b - coord_t'(1) : b + coord_t'(1);
        end
        err <= err_next;
      end
      if (state == ST_FILL) begin
        widx <= widx + IDX_W'(1);
        rem <= rem - count_t'(1);
      end else if (state == ST_PRIME) begin
        rem <= span;
      end else if (issue) begin
        rem <= rem - count_t'(1);
      end
    end
    if (issue) begin
      bx <= gx;
      by <= gy;
      b_cnt_last <= (rem == count_t'(1));
    end
    if (b_move) begin
      obeat.cell_x <= bx;
      obeat.cell_y <= by;
      obeat.last_cell <= b_last;
    end
  end

  assign cells.valid = ov;
  assign cells.data = obeat;

  glos_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .re    (grid_re),
    .raddr (cell_addr(gx, gy)),
    .rdata (grid_rdata)
  );

  glos_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (GRID_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (widx),
    .wdata ({sy, sx}),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  a_lookup_in_run: assert property (@(posedge clk) disable iff (rst)
    pb |-> (state == ST_RUN))
    else $error("opacity lookup pending outside of a ray");

  a_fin_drains: assert property (@(posedge clk) disable iff (rst)
    fin |=> (!gen_valid && !pb))
    else $error("ray pipeline not emptied after its final cell");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!ov && !gen_valid && !pb))
    else $error("ray activity during the grid clearing pass");
endmodule

`default_nettype wire

// File: design/grid_line_of_sight_caster_unit.sv
// Top level of the grid line-of-sight caster: configuration, front end, queue, ray engine.
//
//   channel  | dir | payload                               | handshake
//   ---------+-----+---------------------------------------+------------------
//   items    | in  | cmd, target_x, target_y, opaque_in     | valid/ready beat
//   cells    | out | cell_x, cell_y, last_cell              | valid/ready beat
//   cfg      | in  | cfg_index, cfg_data                    | cfg_we, no wait
//
// After reset the engine sweeps the opacity grid clean, one cell a cycle, through
// all GRID_SIZE*GRID_SIZE cells (4096 at the default size); items.ready stays low
// during that pass while configuration writes are still taken.
// A write item is done by the engine in its idle state. A forward ray of N cells
// emits one cell a cycle, each read through the registered read port of the grid RAM.
// A reversed ray first traces its N cells into the path store, primes one read,
// then plays the cells back at one a cycle. Both rates hold while the cells
// channel is ready; a stall holds the engine while the two-entry queue fills up.
`default_nettype none

module grid_line_of_sight_caster_unit #(
  parameter int GRID_SIZE = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  glos_item_if.sink             items,
  glos_cell_if.source           cells,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire glos_pkg::coord_t cfg_data
);
  import glos_pkg::*;

  // Viewer origin; the user must write it only while the block is quiet, the block does not enforce this.
  coord_t origin_x, origin_y;

  logic clearing;
  logic q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  op_t  q_push_op, q_pop_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front end sorts each beat into a grid write, a forward walk or a reversed
  // trace, and drops items whose coordinates fall off a grid narrower than 64.
  glos_front #(
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .items    (items),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .clearing (clearing),
    .q_ready  (q_push_ready),
    .q_valid  (q_push_valid),
    .op       (q_push_op)
  );

  glos_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_op    (q_push_op),
    .push_ready (q_push_ready),
    .pop_valid  (q_pop_valid),
    .pop_op     (q_pop_op),
    .pop_ready  (q_pop_ready)
  );

  // The engine steps the doubled-error Bresenham line one cell per cycle unless its
  // output stalls, looks each cell up in the grid and stops on the first opaque one.
  glos_back #(
    .GRID_SIZE (GRID_SIZE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (q_pop_valid),
    .op       (q_pop_op),
    .op_ready (q_pop_ready),
    .cells    (cells),
    .clearing (clearing)
  );
endmodule

`default_nettype wire

// File: tb/grid_line_of_sight_caster_unit_tb.sv
// Self-checking testbench of the grid line-of-sight caster: directed table, then random phases.
`timescale 1ns / 100ps

module grid_line_of_sight_caster_unit_tb;
  import glos_pkg::*;

  localparam int GRID_SIZE       = 64;
  localparam int RESET_CYCLES    = 12;
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 50;
  // A write item leaves no result behind. Two of them can sit in the input
  // queue and one in the engine, so this wait after the last cell is
  // more than enough before the origin may change.
  localparam int SETTLE_CYCLES   = 40;
  localparam int TAIL_CYCLES     = 200;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int REPORT_LIMIT    = 10;
  // Slowest correct run: the clearing pass, then about 275 items, each casting up
  // to 64 cells, every cell waiting out a choppy receiver, plus sender gaps and
  // one long hold-off. That stays well under the limit.
  localparam int CYCLE_LIMIT     = 1_000_000;

  typedef enum int {
    ROW_ORIGIN,
    ROW_WRITE,
    ROW_CAST
  } row_kind_t;

  typedef enum int {
    RX_OPEN,
    RX_CHOPPY,
    RX_ALTERNATE
  } rx_mode_t;

  // One row of the directed table. A typed row carries its single expected
  // cell, which is then the last cell of that ray.
  typedef struct {
    row_kind_t kind;
    int        x;
    int        y;
    bit        opq;
    bit        typed;
    int        wx;
    int        wy;
  } stim_row_t;

  logic   clk;
  logic   rst;
  logic   cfg_we;
  logic   cfg_index;
  coord_t cfg_data;

  glos_item_if items_ch ();
  glos_cell_if cells_ch ();

  grid_line_of_sight_caster_unit #(
    .GRID_SIZE (GRID_SIZE)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .items     (items_ch),
    .cells     (cells_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the block: opacity grid indexed [row][column], and the viewer.
  bit        opacity [GRID_SIZE][GRID_SIZE];
  coord_t    view_x;
  coord_t    view_y;

  // Cells the block still owes us, oldest first.
  cell_t     cells_due[$];
  stim_row_t directed_rows[$];

  int cycle_count   = 0;
  int failures      = 0;
  int cells_checked = 0;
  int casts_sent    = 0;
  int writes_sent   = 0;
  int origins_used  = 0;
  int longest_ray   = 0;
  int phase_index   = -1;
  int burst_left    = 0;
  bit no_gaps       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic cell_t make_cell(input int x, input int y, input bit last);
    cell_t c;
    c.cell_x    = coord_t'(x);
    c.cell_y    = coord_t'(y);
    c.last_cell = last;
    return c;
  endfunction

  // Mostly uniform, with one pick in four landing on a grid edge.
  function automatic coord_t random_coord();
    if ($urandom_range(0, 3) == 0)
      return coord_t'(63 * $urandom_range(0, 1));
    return coord_t'($urandom_range(0, 63));
  endfunction

  // Works out the cells a cast to (tx_in, ty_in) reaches from the current
  // viewer and queues them. Opacity is looked up as the cells go out, so a
  // reversed ray is traced whole first and only then tested, nearest first.
  function automatic void trace_ray(input coord_t tx_in, input coord_t ty_in);
    cell_t ray[$];
    cell_t path[$];
    cell_t c;
    int    ox, oy, tx, ty, x, y, sx, sy;
    int    dxa, dya, a1, b1, a2, b2, da, db, bstep, err, a, b, swap;
    bit    steep, rev, blocked;
    ox = view_x;
    oy = view_y;
    tx = tx_in;
    ty = ty_in;
    if (ox == tx || oy == ty) begin
      // Straight rays, and the cast to the viewer itself, keep both ends.
      x  = ox;
      y  = oy;
      sx = (tx > ox) ? 1 : ((tx < ox) ? -1 : 0);
      sy = (ty > oy) ? 1 : ((ty < oy) ? -1 : 0);
      forever begin
        ray = {ray, make_cell(x, y, 1'b0)};
        if (opacity[y][x] || (x == tx && y == ty) || ray.size() >= GRID_SIZE)
          break;
        x += sx;
        y += sy;
      end
    end else begin
      dxa   = (tx > ox) ? tx - ox : ox - tx;
      dya   = (ty > oy) ? ty - oy : oy - ty;
      steep = dya > dxa;
      a1    = steep ? oy : ox;
      b1    = steep ? ox : oy;
      a2    = steep ? ty : tx;
      b2    = steep ? tx : ty;
      // A target behind the viewer on the major axis is traced from the
      // target end, which drops the viewer cell and keeps the target.
      rev   = a1 > a2;
      if (rev) begin
        swap = a1; a1 = a2; a2 = swap;
        swap = b1; b1 = b2; b2 = swap;
      end
      da      = a2 - a1;
      db      = (b2 > b1) ? b2 - b1 : b1 - b2;
      bstep   = (b1 < b2) ? 1 : -1;
      err     = da;
      b       = b1;
      blocked = 1'b0;
      for (a = a1; a < a2 && !blocked; a++) begin
        x = steep ? b : a;
        y = steep ? a : b;
        if (rev) begin
          path = {path, make_cell(x, y, 1'b0)};
        end else begin
          ray = {ray, make_cell(x, y, 1'b0)};
          blocked = opacity[y][x];
        end
        // Doubled error term: whole numbers only.
        err -= 2 * db;
        if (err < 0) begin
          b   += bstep;
          err += 2 * da;
        end
      end
      while (path.size() > 0 && !blocked) begin
        c = path[path.size() - 1];
        path.delete(path.size() - 1);
        ray = {ray, c};
        blocked = opacity[c.cell_y][c.cell_x];
      end
    end
    ray[ray.size() - 1].last_cell = 1'b1;
    if (ray.size() > longest_ray)
      longest_ray = ray.size();
    cells_due = {cells_due, ray};
  endfunction

  function automatic void apply_item(input item_t it);
    if (it.cmd == CMD_WRITE) begin
      opacity[it.target_y][it.target_x] = it.opaque_in;
      writes_sent++;
    end else begin
      trace_ray(it.target_x, it.target_y);
      casts_sent++;
    end
  endfunction

  function automatic void add_row(input row_kind_t kind, input int x, input int y,
                                  input bit opq, input bit typed, input int wx,
                                  input int wy);
    stim_row_t r;
    r.kind  = kind;
    r.x     = x;
    r.y     = y;
    r.opq   = opq;
    r.typed = typed;
    r.wx    = wx;
    r.wy    = wy;
    directed_rows = {directed_rows, r};
  endfunction

  // Sender pacing: bursts of random length, with a random gap before each
  // burst unless the current phase runs without gaps. While valid is low the
  // payload carries noise.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = no_gaps ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        items_ch.valid <= 1'b0;
        items_ch.data  <= item_t'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Offers one item and returns at the edge where its beat is taken.
  task automatic offer(input item_t it);
    items_ch.valid <= 1'b1;
    items_ch.data  <= it;
    @(posedge clk);
    while (items_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // Lets the block run dry: every owed cell seen, then time for any write
  // items still in flight to land.
  task automatic settle_block();
    items_ch.valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Two back-to-back register writes; the block is idle when this is called.
  task automatic set_origin(input int x, input int y);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ORIGIN_X;
    cfg_data  <= coord_t'(x);
    @(posedge clk);
    cfg_index <= REG_ORIGIN_Y;
    cfg_data  <= coord_t'(y);
    @(posedge clk);
    cfg_we    <= 1'b0;
    view_x = coord_t'(x);
    view_y = coord_t'(y);
    origins_used++;
  endtask

  // Receiver: switches between an open, a choppy and an alternating ready
  // pattern at random intervals. Once the second random phase begins it
  // holds ready low for a long counted stretch, so the engine and the input
  // queue fill up and the sender is made to wait.
  initial begin : cell_receiver
    int       mode_left;
    int       hold_left;
    bit       hold_done;
    bit       rdy;
    rx_mode_t mode;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    rdy       = 1'b0;
    mode      = RX_OPEN;
    cells_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && phase_index == 1) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (mode)
          RX_OPEN:      rdy = 1'b1;
          RX_CHOPPY:    rdy = ($urandom_range(0, 9) >= 3);
          default:      rdy = ~rdy;
        endcase
      end
      cells_ch.ready <= rdy;
    end
  end

  // Checker: every cell beat is matched, field by field, against the oldest
  // owed cell. A beat with nothing owed is a failure too.
  always @(posedge clk) begin : cell_checker
    cell_t want;
    if (!rst && cells_ch.valid === 1'b1 && cells_ch.ready === 1'b1) begin
      cells_checked++;
      if (cells_due.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("cycle %0d: unexpected cell (%0d,%0d) last=%0d", cycle_count,
                   cells_ch.data.cell_x, cells_ch.data.cell_y, cells_ch.data.last_cell);
      end else begin
        want = cells_due.pop_front();
        if (cells_ch.data.cell_x !== want.cell_x || cells_ch.data.cell_y !== want.cell_y ||
            cells_ch.data.last_cell !== want.last_cell) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("cycle %0d: expected (%0d,%0d) last=%0d, got (%0d,%0d) last=%0d",
                     cycle_count, want.cell_x, want.cell_y, want.last_cell,
                     cells_ch.data.cell_x, cells_ch.data.cell_y, cells_ch.data.last_cell);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d cells still owed", cycle_count, cells_due.size());
    $display("FAIL grid_line_of_sight_caster_unit");
    $finish;
  end

  initial begin : stimulus
    stim_row_t row;
    item_t     it;
    int        nx;
    int        ny;
    int        pick;
    int        n;
    int        phase;

    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_ORIGIN_X;
    cfg_data       <= '0;
    items_ch.valid <= 1'b0;
    items_ch.data  <= '0;
    view_x = '0;
    view_y = '0;

    // Directed table. The first rows run with the reset viewer at the corner.
    add_row(ROW_CAST,    0,  0, 1'b0, 1'b1,  0,  0); // cast to the viewer itself
    add_row(ROW_CAST,   63,  0, 1'b0, 1'b0,  0,  0); // full-length horizontal
    add_row(ROW_CAST,    0, 63, 1'b1, 1'b0,  0,  0); // full-length vertical
    add_row(ROW_CAST,   63, 63, 1'b0, 1'b0,  0,  0); // main diagonal, forward
    add_row(ROW_CAST,   63, 20, 1'b0, 1'b0,  0,  0); // shallow, forward
    add_row(ROW_CAST,   20, 63, 1'b0, 1'b0,  0,  0); // steep, forward
    add_row(ROW_WRITE,   0,  0, 1'b1, 1'b0,  0,  0);
    add_row(ROW_CAST,   63, 63, 1'b0, 1'b1,  0,  0); // opaque viewer blocks at once
    add_row(ROW_CAST,    0,  0, 1'b1, 1'b1,  0,  0); // opacity bit ignored on a cast
    add_row(ROW_WRITE,   0,  0, 1'b0, 1'b0,  0,  0);
    add_row(ROW_ORIGIN, 63, 63, 1'b0, 1'b0,  0,  0);
    add_row(ROW_CAST,   63, 63, 1'b0, 1'b1, 63, 63); // viewer at the far corner
    add_row(ROW_CAST,    0,  0, 1'b0, 1'b0,  0,  0); // diagonal, reversed
    add_row(ROW_CAST,    0, 63, 1'b0, 1'b0,  0,  0); // horizontal, backward
    add_row(ROW_CAST,   63,  0, 1'b0, 1'b0,  0,  0); // vertical, backward
    add_row(ROW_CAST,   10, 40, 1'b0, 1'b0,  0,  0); // shallow, reversed
    add_row(ROW_WRITE,  62, 62, 1'b1, 1'b0,  0,  0);
    add_row(ROW_CAST,    0,  0, 1'b0, 1'b1, 62, 62); // reversed ray blocked beside viewer
    add_row(ROW_WRITE,  62, 62, 1'b0, 1'b0,  0,  0);
    add_row(ROW_ORIGIN, 32, 31, 1'b0, 1'b0,  0,  0);
    add_row(ROW_WRITE,  40, 35, 1'b1, 1'b0,  0,  0);
    add_row(ROW_CAST,   63, 40, 1'b0, 1'b0,  0,  0);
    add_row(ROW_CAST,    5, 50, 1'b1, 1'b0,  0,  0); // shallow, reversed
    add_row(ROW_WRITE,  63, 63, 1'b1, 1'b0,  0,  0);
    add_row(ROW_CAST,   63, 63, 1'b0, 1'b0,  0,  0); // opaque target never reached
    add_row(ROW_CAST,    0, 31, 1'b0, 1'b0,  0,  0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Items are offered straight away; ready stays low through the clearing
    // pass, so the first beat simply waits for it.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_ORIGIN) begin
        settle_block();
        set_origin(row.x, row.y);
      end else begin
        it.cmd       = (row.kind == ROW_CAST) ? CMD_CAST : CMD_WRITE;
        it.target_x  = coord_t'(row.x);
        it.target_y  = coord_t'(row.y);
        it.opaque_in = row.opq;
        pace();
        offer(it);
        if (row.typed) begin
          cells_due = {cells_due, make_cell(row.wx, row.wy, 1'b1)};
          casts_sent++;
        end else begin
          apply_item(it);
        end
      end
    end

    // Random phases, each from a fresh viewer. The block is drained before
    // every origin change. The first phase runs the sender without gaps.
    for (phase = 0; phase < PHASES; phase++) begin
      settle_block();
      case (phase)
        0:       set_origin(0, 63);
        1:       set_origin(63, 0);
        default: set_origin(random_coord(), random_coord());
      endcase
      phase_index = phase;
      no_gaps     = (phase == 0);
      burst_left  = 0;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        it.opaque_in = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 1) begin
          // Casts lean toward the special shapes: the viewer itself,
          // straight rays and grid edges.
          it.cmd      = CMD_CAST;
          it.target_x = random_coord();
          it.target_y = random_coord();
          pick        = $urandom_range(0, 9);
          if (pick == 0) begin
            it.target_x = view_x;
            it.target_y = view_y;
          end else if (pick == 1) begin
            it.target_x = view_x;
          end else if (pick == 2) begin
            it.target_y = view_y;
          end
        end else begin
          // Half the writes land near the viewer, where they can block rays.
          it.cmd       = CMD_WRITE;
          it.opaque_in = ($urandom_range(0, 2) == 0);
          if ($urandom_range(0, 1) == 1) begin
            nx = int'(view_x) + int'($urandom_range(0, 14)) - 7;
            ny = int'(view_y) + int'($urandom_range(0, 14)) - 7;
            nx = (nx < 0) ? 0 : ((nx > 63) ? 63 : nx);
            ny = (ny < 0) ? 0 : ((ny > 63) ? 63 : ny);
            it.target_x = coord_t'(nx);
            it.target_y = coord_t'(ny);
          end else begin
            it.target_x = coord_t'($urandom_range(0, 63));
            it.target_y = coord_t'($urandom_range(0, 63));
          end
        end
        pace();
        offer(it);
        apply_item(it);
      end
    end

    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    failures += cells_due.size();

    $display("Ran %0d casts and %0d opacity writes from %0d viewer origins.",
             casts_sent, writes_sent, origins_used);
    $display("Checked %0d cells, longest ray %0d cells, in %0d cycles; %0d failures.",
             cells_checked, longest_ray, cycle_count, failures);
    if (failures == 0) begin
      $display("PASS grid_line_of_sight_caster_unit");
    end else begin
      $display("FAIL grid_line_of_sight_caster_unit");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/glos_pkg.sv
design/glos_if.sv
design/glos_ram.sv
design/glos_front.sv
design/glos_queue.sv
design/glos_back.sv
design/grid_line_of_sight_caster_unit.sv
tb/grid_line_of_sight_caster_unit_tb.sv
